[sv/stq_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the sorted timer queue.
// No dependencies; used by stq_div, stq_cell and sorted_timer_queue_core.
package stq_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int KEY_W      = 16;
  localparam int DELAY_W    = 31;
  localparam int TICK_W     = 32;
  localparam int IDLE_W     = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_SLEEP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HALTED     = 1'd1;

  localparam logic [IDLE_W-1:0] IDLE_SLEEP_RESET = 16'd15;

  // A run pops at most this many entries
  localparam int MAX_RESULTS = 16;
  localparam int RUN_CNT_W   = $clog2(MAX_RESULTS);

  // ms to ticks: delay * 60 / 1000, reduced to delay * 3 / 50
  localparam int TICKS_PER_SEC = 60;
  localparam int MS_PER_SEC    = 1000;
  localparam int RATE_GCD      = 20;
  localparam int SCALE_NUM     = TICKS_PER_SEC / RATE_GCD;
  localparam int SCALE_DEN     = MS_PER_SEC / RATE_GCD;
  localparam int SCALED_W      = DELAY_W + 2;

  // Digit-serial long division by SCALE_DEN
  localparam int DIG_W    = 9;
  localparam int DIG_CNT  = (SCALED_W + DIG_W - 1) / DIG_W;
  localparam int DIV_X_W  = DIG_W * DIG_CNT;
  localparam int REM_W    = $clog2(SCALE_DEN);
  localparam int PART_W   = REM_W + DIG_W;
  localparam int RECIP_SH = 20;
  localparam int RECIP_M  = (2 ** RECIP_SH + SCALE_DEN - 1) / SCALE_DEN;
  localparam int PROD_W   = 2 * PART_W;
  localparam int DCNT_W   = $clog2(DIG_CNT);

  // Cell commands
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_REMOVE = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_POP    = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TICK_W-1:0] due;
  } cell_ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [DELAY_W-1:0] delay_ms;
    logic [TICK_W-1:0]  now_ticks;
  } in_t;

  typedef struct packed {
    logic               fired;
    logic [KEY_W-1:0]   fired_key;
    logic               status;
    logic               queue_active;
    logic [TICK_W-1:0]  head_due;
    logic [DELAY_W-1:0] next_delay;
    logic               last;
  } out_t;

  // Build one result item from the queue head and the current tick
  function automatic out_t make_result(
    input logic              any,
    input logic              active_ok,
    input logic [TICK_W-1:0] head,
    input logic [TICK_W-1:0] now,
    input logic [IDLE_W-1:0] idle,
    input logic              fired,
    input logic [KEY_W-1:0]  fkey,
    input logic              status,
    input logic              last
  );
    out_t              r;
    logic [TICK_W-1:0] d;
    d              = head - now;
    r.fired        = fired;
    r.fired_key    = fkey;
    r.status       = status;
    r.queue_active = any & active_ok;
    r.head_due     = any ? head : '0;
    if (!any) begin
      r.next_delay = DELAY_W'(idle);
    end else if ((d == '0) || d[TICK_W-1]) begin
      r.next_delay = '0;
    end else begin
      r.next_delay = d[DELAY_W-1:0];
    end
    r.last         = last;
    return r;
  endfunction

endpackage

[sv/stq_div.sv]
`timescale 1ns / 1ps
// Converts a millisecond delay to ticks, one quotient digit per cycle.
// Depends on stq_pkg.
module stq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stq_pkg::DELAY_W-1:0] delay_ms,
  output logic                        busy,
  output logic [stq_pkg::TICK_W-1:0]  quot
);

  logic                         busy_r, busy_nxt;
  logic [stq_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [stq_pkg::DIV_X_W-1:0]  x_r, x_nxt;
  logic [stq_pkg::DIV_X_W-1:0]  q_r, q_nxt;
  logic [stq_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [stq_pkg::SCALED_W-1:0] scaled;
  logic [stq_pkg::PART_W-1:0]   part;
  logic [stq_pkg::PROD_W-1:0]   prod;
  logic [stq_pkg::DIG_W-1:0]    qd;
  logic [stq_pkg::PART_W-1:0]   back;

  // Digit step: partial = rem:digit, digit quotient by reciprocal multiply
  always_comb begin
    scaled  = stq_pkg::SCALED_W'(delay_ms) * stq_pkg::SCALED_W'(stq_pkg::SCALE_NUM);
    part    = {rem_r, x_r[stq_pkg::DIV_X_W-1 -: stq_pkg::DIG_W]};
    prod    = stq_pkg::PROD_W'(part) * stq_pkg::PROD_W'(stq_pkg::RECIP_M);
    qd      = stq_pkg::DIG_W'(prod >> stq_pkg::RECIP_SH);
    back    = stq_pkg::PART_W'(qd) * stq_pkg::PART_W'(stq_pkg::SCALE_DEN);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = stq_pkg::DIV_X_W'(scaled);
      q_nxt    = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      x_nxt   = x_r << stq_pkg::DIG_W;
      q_nxt   = {q_r[stq_pkg::DIV_X_W-stq_pkg::DIG_W-1:0], qd};
      rem_nxt = stq_pkg::REM_W'(part - back);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == stq_pkg::DCNT_W'(stq_pkg::DIG_CNT - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r[stq_pkg::TICK_W-1:0];

endmodule

[sv/stq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted queue: holds a due tick and a key and shifts
// toward either neighbor on remove, insert or pop. Depends on stq_pkg.
module stq_cell #(
  parameter int KW = 16
) (
  input  logic                       clk,
  input  stq_pkg::cell_ctrl_t        ctrl,
  input  logic [KW-1:0]              ins_key,
  input  logic                       occ,
  input  logic                       left_occ,
  input  logic                       left_gt,
  input  logic [stq_pkg::TICK_W-1:0] left_due,
  input  logic [KW-1:0]              left_key,
  input  logic [stq_pkg::TICK_W-1:0] right_due,
  input  logic [KW-1:0]              right_key,
  input  logic                       hit_i,
  output logic                       hit_o,
  output logic                       gt_o,
  output logic [stq_pkg::TICK_W-1:0] due_o,
  output logic [KW-1:0]              key_o
);

  logic [stq_pkg::TICK_W-1:0] due_r, due_nxt;
  logic [KW-1:0]              key_r, key_nxt;

  // Local compares, then pick own, left, right or the new entry
  always_comb begin
    hit_o   = hit_i | (occ & (key_r == ins_key));
    gt_o    = occ & (due_r > ctrl.due);
    due_nxt = due_r;
    key_nxt = key_r;
    case (ctrl.cmd)
      stq_pkg::CELL_REMOVE: begin
        if (hit_o) begin
          due_nxt = right_due;
          key_nxt = right_key;
        end
      end
      stq_pkg::CELL_INSERT: begin
        if (left_gt) begin
          due_nxt = left_due;
          key_nxt = left_key;
        end else if (left_occ && (gt_o || !occ)) begin
          due_nxt = ctrl.due;
          key_nxt = ins_key;
        end
      end
      stq_pkg::CELL_POP: begin
        due_nxt = right_due;
        key_nxt = right_key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    key_r <= key_nxt;
  end

  assign due_o = due_r;
  assign key_o = key_r;

endmodule

[sv/sorted_timer_queue_core.sv]
`timescale 1ns / 1ps
// Sorted timer queue: a chain of slot cells, a sequencer and an output register.
// Depends on stq_pkg, stq_div and stq_cell.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | in_data  (stq_pkg::in_t)
//   out_       | out | out_valid/out_ready| out_data (stq_pkg::out_t)
//   cfg_       | in  | cfg_we             | cfg_addr, cfg_wdata
//
// A schedule spends most of its time on the four-digit ms to tick division, and a
// run pops one fired entry at a time.
// Every queue change is one shift step through the cell chain.
// Reset (rst_n low, synchronous) empties the queue and loads register defaults.
// A result waits in the output register; a new item is taken meanwhile, and the
// sequencer stalls only for the divider or to deliver the next result into a full register.
module sorted_timer_queue_core #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  stq_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stq_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [stq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [stq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW = (KEY_BITS < stq_pkg::KEY_W) ? KEY_BITS : stq_pkg::KEY_W;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REMOVE = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_RUN    = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [stq_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [KW-1:0]                  key_r, key_nxt;
  logic [stq_pkg::TICK_W-1:0]     now_r, now_nxt;
  logic                           status_r, status_nxt;
  logic [stq_pkg::RUN_CNT_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           out_valid_r, out_valid_nxt;
  stq_pkg::out_t                  out_data_r, out_data_nxt;
  logic [stq_pkg::IDLE_W-1:0]     idle_sleep_r, idle_sleep_nxt;
  logic                           halted_r, halted_nxt;

  logic                           in_xfer;
  logic                           can_emit;
  logic                           full;
  logic [stq_pkg::TICK_W-1:0]     ins_due;
  logic                           div_busy;
  logic [stq_pkg::TICK_W-1:0]     div_quot;
  stq_pkg::cell_ctrl_t            cell_ctrl;

  logic                           head_exp;
  logic                           any_after;
  logic                           next_exp;
  logic                           last_pop;
  logic                           pop;

  // Chain wiring; index DEPTH of the data arrays is a zero pad past the tail
  logic [stq_pkg::TICK_W-1:0]     due_c [0:DEPTH];
  logic [KW-1:0]                  key_c [0:DEPTH];
  logic [DEPTH:0]                 hit_c;
  logic [DEPTH-1:0]               gt_w;
  logic [DEPTH-1:0]               occ_w;
  logic [DEPTH-1:0]               unsorted_w;

  assign due_c[DEPTH] = '0;
  assign key_c[DEPTH] = '0;
  assign hit_c[0]     = 1'b0;

  // Divider for the ms to tick conversion
  stq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer && (in_data.op == stq_pkg::OP_SCHEDULE)),
    .delay_ms (in_data.delay_ms),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // Cell chain
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                       l_occ;
      logic                       l_gt;
      logic [stq_pkg::TICK_W-1:0] l_due;
      logic [KW-1:0]              l_key;

      assign occ_w[gi] = (count_r > CW'(gi));

      if (gi == 0) begin : g_head
        assign l_occ = 1'b1;
        assign l_gt  = 1'b0;
        assign l_due = due_c[0];
        assign l_key = key_c[0];
      end else begin : g_body
        assign l_occ = occ_w[gi-1];
        assign l_gt  = gt_w[gi-1];
        assign l_due = due_c[gi-1];
        assign l_key = key_c[gi-1];
      end

      // Out-of-order flag for adjacent occupied slots
      if (gi < DEPTH - 1) begin : g_ord
        assign unsorted_w[gi] = occ_w[gi+1] && (due_c[gi] > due_c[gi+1]);
      end else begin : g_ord_tail
        assign unsorted_w[gi] = 1'b0;
      end

      stq_cell #(.KW(KW)) u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .ins_key   (key_r),
        .occ       (occ_w[gi]),
        .left_occ  (l_occ),
        .left_gt   (l_gt),
        .left_due  (l_due),
        .left_key  (l_key),
        .right_due (due_c[gi+1]),
        .right_key (key_c[gi+1]),
        .hit_i     (hit_c[gi]),
        .hit_o     (hit_c[gi+1]),
        .gt_o      (gt_w[gi]),
        .due_o     (due_c[gi]),
        .key_o     (key_c[gi])
      );
    end
  endgenerate

  // Handshake and run-loop conditions
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    in_xfer   = in_valid && in_ready;
    can_emit  = !out_valid_r || out_ready;
    full      = (count_r == CW'(DEPTH));
    ins_due   = now_r + div_quot;
    head_exp  = (count_r != '0) && !(due_c[0] > now_r);
    any_after = (count_r > CW'(1));
    next_exp  = any_after && !(due_c[1] > now_r);
    last_pop  = !next_exp || (run_cnt_r == stq_pkg::RUN_CNT_W'(stq_pkg::MAX_RESULTS - 1));
    pop       = (state_r == ST_RUN) && !halted_r && head_exp && can_emit;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    status_nxt    = status_r;
    run_cnt_nxt   = run_cnt_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cell_ctrl.cmd = stq_pkg::CELL_HOLD;
    cell_ctrl.due = ins_due;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt      = in_data.op;
          key_nxt     = in_data.key[KW-1:0];
          now_nxt     = in_data.now_ticks;
          status_nxt  = 1'b0;
          run_cnt_nxt = '0;
          if ((in_data.op == stq_pkg::OP_SCHEDULE) || (in_data.op == stq_pkg::OP_CANCEL)) begin
            state_nxt = ST_REMOVE;
          end else if (in_data.op == stq_pkg::OP_RUN) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_REMOVE: begin
        // Drop any entry with this key; the chain closes the gap
        cell_ctrl.cmd = stq_pkg::CELL_REMOVE;
        if (hit_c[DEPTH]) begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = (op_r == stq_pkg::OP_SCHEDULE) ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        status_nxt = full;
        if (!full) begin
          cell_ctrl.cmd = stq_pkg::CELL_INSERT;
          count_nxt     = count_r + CW'(1);
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = stq_pkg::make_result(count_r != '0, 1'b1, due_c[0], now_r,
                                               idle_sleep_r, 1'b0, '0, status_r, 1'b1);
          state_nxt     = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (pop) begin
          // Report the popped head along with the queue as it stands after
          cell_ctrl.cmd = stq_pkg::CELL_POP;
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = stq_pkg::make_result(any_after, 1'b1, due_c[1], now_r,
                                               idle_sleep_r, 1'b1,
                                               stq_pkg::KEY_W'(key_c[0]), 1'b0, last_pop);
          run_cnt_nxt   = run_cnt_r + 1'b1;
          if (last_pop) begin
            state_nxt = ST_IDLE;
          end
        end else if (can_emit) begin
          // Nothing due, or halted: one empty result
          out_valid_nxt = 1'b1;
          out_data_nxt  = stq_pkg::make_result(count_r != '0, !halted_r, due_c[0], now_r,
                                               idle_sleep_r, 1'b0, '0, 1'b0, 1'b1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    idle_sleep_nxt = idle_sleep_r;
    halted_nxt     = halted_r;
    if (cfg_we) begin
      case (cfg_addr)
        stq_pkg::REG_IDLE_SLEEP: idle_sleep_nxt = cfg_wdata[stq_pkg::IDLE_W-1:0];
        stq_pkg::REG_HALTED:     halted_nxt     = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      idle_sleep_r <= stq_pkg::IDLE_SLEEP_RESET;
      halted_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      idle_sleep_r <= idle_sleep_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    status_r   <= status_nxt;
    run_cnt_r  <= run_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not add an entry");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    unsorted_w == '0)
    else $error("occupied slots out of due order");

  a_halt_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && halted_r) |-> (cell_ctrl.cmd != stq_pkg::CELL_POP))
    else $error("entry popped while halted");

endmodule

[tb/sv/stq_timer_checker.sv]
`timescale 1ns / 1ps
// Checker for sorted_timer_queue_core: watches the input, result and register ports,
// keeps its own copy of the timer queue and compares every result transfer.
// Depends on stq_pkg.
module stq_timer_checker
  import stq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_t                    in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatch_total,
  output int                     reports_due
);

  // Shadow queue, sorted by due tick, earliest first
  logic [TICK_W-1:0] due_tbl [DEPTH];
  logic [KEY_W-1:0]  key_tbl [DEPTH];
  int                held;
  logic [IDLE_W-1:0] idle_sleep;
  logic              halted_q;

  out_t              timer_reports [$];

  // Status report built from the current head of the shadow queue
  function automatic out_t describe(
    input logic              fired,
    input logic [KEY_W-1:0]  fkey,
    input logic              status,
    input logic              active_ok,
    input logic [TICK_W-1:0] now,
    input logic              last
  );
    out_t              r;
    logic [TICK_W-1:0] gap;
    r.fired        = fired;
    r.fired_key    = fkey;
    r.status       = status;
    r.queue_active = (held > 0) && active_ok;
    r.head_due     = (held > 0) ? due_tbl[0] : '0;
    gap            = r.head_due - now;
    if (held == 0) begin
      r.next_delay = DELAY_W'(idle_sleep);
    end else if (gap == '0 || gap[TICK_W-1]) begin
      r.next_delay = '0;  // due now or overdue
    end else begin
      r.next_delay = gap[DELAY_W-1:0];
    end
    r.last         = last;
    return r;
  endfunction

  task automatic remove_slot(input int pos);
    for (int i = pos; i + 1 < held; i++) begin
      due_tbl[i] = due_tbl[i+1];
      key_tbl[i] = key_tbl[i+1];
    end
    held--;
  endtask

  task automatic remove_key(input logic [KEY_W-1:0] k);
    int hit;
    hit = -1;
    for (int i = 0; i < held; i++) begin
      if (hit < 0 && key_tbl[i] == k) hit = i;
    end
    if (hit >= 0) remove_slot(hit);
  endtask

  // Apply one accepted request and queue the reports it causes
  task automatic advance_timer_model(input in_t req);
    logic [63:0]       scaled;
    logic [TICK_W-1:0] due;
    logic [KEY_W-1:0]  fkey;
    int                pos;
    int                pops;
    logic              more;
    case (req.op)
      OP_SCHEDULE: begin
        remove_key(req.key);
        if (held >= DEPTH) begin
          timer_reports.push_back(describe(1'b0, '0, 1'b1, 1'b1, req.now_ticks, 1'b1));
        end else begin
          scaled = 64'(req.delay_ms) * TICKS_PER_SEC / MS_PER_SEC;
          due    = req.now_ticks + scaled[TICK_W-1:0];
          // goes behind every entry due at or before it
          pos = 0;
          while (pos < held && due_tbl[pos] <= due) pos++;
          for (int i = held; i > pos; i--) begin
            due_tbl[i] = due_tbl[i-1];
            key_tbl[i] = key_tbl[i-1];
          end
          due_tbl[pos] = due;
          key_tbl[pos] = req.key;
          held++;
          timer_reports.push_back(describe(1'b0, '0, 1'b0, 1'b1, req.now_ticks, 1'b1));
        end
      end
      OP_CANCEL: begin
        remove_key(req.key);
        timer_reports.push_back(describe(1'b0, '0, 1'b0, 1'b1, req.now_ticks, 1'b1));
      end
      OP_RUN: begin
        if (halted_q) begin
          timer_reports.push_back(describe(1'b0, '0, 1'b0, 1'b0, req.now_ticks, 1'b1));
        end else begin
          pops = 0;
          more = (held > 0) && (due_tbl[0] <= req.now_ticks);
          if (!more) begin
            timer_reports.push_back(describe(1'b0, '0, 1'b0, 1'b1, req.now_ticks, 1'b1));
          end
          while (more) begin
            fkey = key_tbl[0];
            remove_slot(0);
            pops++;
            more = (pops < MAX_RESULTS) && (held > 0) && (due_tbl[0] <= req.now_ticks);
            timer_reports.push_back(describe(1'b1, fkey, 1'b0, 1'b1, req.now_ticks, !more));
          end
        end
      end
      default: begin
        timer_reports.push_back(describe(1'b0, '0, 1'b0, 1'b1, req.now_ticks, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        due_tbl[i] = '0;
        key_tbl[i] = '0;
      end
      held           = 0;
      idle_sleep     = IDLE_SLEEP_RESET;
      halted_q       = 1'b0;
      mismatch_total = 0;
      timer_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_IDLE_SLEEP: idle_sleep = cfg_wdata[IDLE_W-1:0];
          REG_HALTED:     halted_q   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_timer_model(in_data);
      // compare each result transfer with the oldest expectation
      if (out_valid && out_ready) begin
        if (timer_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          mismatch_total++;
        end else begin
          want = timer_reports.pop_front();
          check_field("fired", want.fired, out_data.fired);
          check_field("fired_key", want.fired_key, out_data.fired_key);
          check_field("status", want.status, out_data.status);
          check_field("queue_active", want.queue_active, out_data.queue_active);
          check_field("head_due", want.head_due, out_data.head_due);
          check_field("next_delay", want.next_delay, out_data.next_delay);
          check_field("last", want.last, out_data.last);
        end
      end
    end
    reports_due <= timer_reports.size();
  end

endmodule

[tb/sv/tb_sorted_timer_queue_core.sv]
`timescale 1ns / 1ps
// Top of the sorted_timer_queue_core testbench: clock, reset, request and result
// traffic, register phases and the verdict. Depends on stq_pkg, the core and stq_timer_checker.
module tb_sorted_timer_queue_core;
  import stq_pkg::*;

  localparam int              DEPTH          = 16;
  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam int              KEY_POOL       = 24;
  localparam int              LONG_HOLD      = 300;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              DRAIN_CYCLES   = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_t                   in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_t                  out_data;

  int                    mismatch_total;
  int                    reports_due;
  int                    stall_cycles = 0;
  logic [TICK_W-1:0]     tick_now     = '0;
  bit                    quiet        = 1'b0;
  bit                    squeeze_req  = 1'b0;
  bit                    squeeze_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_timer_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  stq_timer_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .mismatch_total(mismatch_total),
    .reports_due(reports_due)
  );

  function automatic in_t timer_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                    input logic [DELAY_W-1:0] delay,
                                    input logic [TICK_W-1:0] now);
    in_t r;
    r.op        = op;
    r.key       = key;
    r.delay_ms  = delay;
    r.now_ticks = now;
    return r;
  endfunction

  // One request transfer, sometimes preceded by an idle burst
  task automatic send_item(input in_t item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Register writes only once every outstanding result has been taken
  task automatic write_regs(input logic [IDLE_W-1:0] idle, input logic halt);
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IDLE_SLEEP;
    cfg_wdata <= CFG_DATA_W'(idle);
    @(posedge clk);
    cfg_addr  <= REG_HALTED;
    cfg_wdata <= CFG_DATA_W'(halt);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a small key pool with a slowly advancing tick, so entries collide,
  // fill the queue and expire; now and then wild keys, delays and tick jumps.
  task automatic run_random(input int count);
    in_t item;
    int  pick;
    int  dpick;
    for (int n = 0; n < count; n++) begin
      pick     = $urandom_range(0, 99);
      dpick    = $urandom_range(0, 99);
      tick_now = tick_now + TICK_W'($urandom_range(0, 40));
      if ($urandom_range(0, 24) == 0) begin
        tick_now = TICK_W'($urandom);
      end else if ($urandom_range(0, 39) == 0) begin
        tick_now = 32'hFFFF_FF00 + TICK_W'($urandom_range(0, 255));
      end
      item.now_ticks = tick_now;
      if ($urandom_range(0, 4) == 0) begin
        item.key = KEY_W'($urandom);
      end else begin
        item.key = KEY_W'($urandom_range(0, KEY_POOL - 1));
      end
      if (pick < 45) begin
        item.op = OP_SCHEDULE;
      end else if (pick < 60) begin
        item.op = OP_CANCEL;
      end else if (pick < 95) begin
        item.op = OP_RUN;
      end else begin
        item.op = OP_UNUSED;
      end
      if (dpick < 50) begin
        item.delay_ms = DELAY_W'($urandom_range(0, 3000));
      end else if (dpick < 80) begin
        item.delay_ms = DELAY_W'($urandom_range(0, 30000));
      end else if (dpick < 92) begin
        item.delay_ms = DELAY_W'($urandom);
      end else if (dpick < 96) begin
        item.delay_ms = '1;
      end else begin
        item.delay_ms = '0;
      end
      send_item(item);
    end
  endtask

  // Result side: random stalls, one long hold-off to back up the queue
  initial begin : result_sink
    int hold;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
        squeeze_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[sorted_timer_queue_core] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, absent cancel, unused op, fill to full, overflow,
    // reschedule while full, one run that drains all sixteen, then empty run.
    send_item(timer_req(OP_RUN, '0, '0, '0));
    send_item(timer_req(OP_CANCEL, 16'h0005, '0, '0));
    send_item(timer_req(OP_UNUSED, 16'hFFFF, '1, '1));
    for (int i = 0; i < 15; i++) begin
      send_item(timer_req(OP_SCHEDULE, KEY_W'(i), DELAY_W'(i * 100), 32'd1000));
    end
    send_item(timer_req(OP_SCHEDULE, 16'hFFFF, '1, '1));  // due tick wraps past zero
    send_item(timer_req(OP_SCHEDULE, 16'h8000, 31'd5, 32'd1000));
    send_item(timer_req(OP_SCHEDULE, 16'h0003, '0, 32'd1000));
    send_item(timer_req(OP_RUN, '0, '0, '1));
    send_item(timer_req(OP_RUN, '0, '0, 32'd1000));

    write_regs('0, 1'b0);
    run_random(50);

    write_regs('1, 1'b1);
    run_random(25);

    write_regs(IDLE_W'($urandom_range(1, 65534)), 1'b0);
    squeeze_req = 1'b1;
    run_random(40);
    quiet = 1'b1;
    run_random(25);

    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && reports_due == 0) begin
      $display("[sorted_timer_queue_core] OK");
    end else begin
      $display("[sorted_timer_queue_core] ERROR");
    end
    $finish;
  end

endmodule
